>>> rtl/core/tcw_pkg.sv
// ----------------------------------------------------------------------------
// Text console writer package
// Screen geometry, field widths, operation and character codes, sweep command.
// ----------------------------------------------------------------------------
package tcw_pkg;

    localparam int COLUMNS    = 80;
    localparam int ROWS       = 25;
    localparam int TAB_SPACES = 4;
    localparam int CELLS      = ROWS * COLUMNS;

    localparam int ADDR_W = 11;
    localparam int COL_W  = 7;
    localparam int ROW_W  = 5;
    localparam int CHAR_W = 8;
    localparam int ATTR_W = 8;
    localparam int CELL_W = 16;
    localparam int OP_W   = 2;
    localparam int TAB_W  = $clog2(TAB_SPACES + 1);

    // Destination range of the scroll copy and the bottom row that follows it.
    localparam int SCROLL_LAST  = (ROWS - 1) * COLUMNS - 1;
    localparam int BOTTOM_FIRST = (ROWS - 1) * COLUMNS;

    localparam logic [OP_W-1:0] OP_PUT   = 2'd0;
    localparam logic [OP_W-1:0] OP_CLEAR = 2'd1;
    localparam logic [OP_W-1:0] OP_READ  = 2'd2;

    localparam logic [CHAR_W-1:0] CH_BACKSPACE = 8'h08;
    localparam logic [CHAR_W-1:0] CH_TAB       = 8'h09;
    localparam logic [CHAR_W-1:0] CH_NEWLINE   = 8'h0A;
    localparam logic [CHAR_W-1:0] CH_SPACE     = 8'h20;

    localparam logic [ATTR_W-1:0] RESET_ATTR  = 8'h0F;
    localparam logic [CELL_W-1:0] RESET_BLANK = {RESET_ATTR, CH_SPACE};

    typedef struct packed {
        logic                  start;
        logic                  copy;
        logic [ADDR_W-1:0]     first;
        logic [ADDR_W-1:0]     last;
        logic [CELL_W-1:0]     fill;
    } sweep_cmd_t;

endpackage

>>> rtl/core/tcw_if.sv
// ----------------------------------------------------------------------------
// Text console writer channels
// Command and response channels with a valid/ready handshake.
// ----------------------------------------------------------------------------
interface tcw_cmd_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [OP_W-1:0]     operation;
    logic [CHAR_W-1:0]   char_code;
    logic [ADDR_W-1:0]   cell_address;

    modport source (output valid, output operation, output char_code,
                    output cell_address, input ready);
    modport sink   (input valid, input operation, input char_code,
                    input cell_address, output ready);
endinterface

interface tcw_rsp_if;
    import tcw_pkg::*;

    logic                valid;
    logic                ready;
    logic [ADDR_W-1:0]   cursor_offset;
    logic [COL_W-1:0]    cursor_column;
    logic [ROW_W-1:0]    cursor_row;
    logic [CELL_W-1:0]   cell_data;

    modport source (output valid, output cursor_offset, output cursor_column,
                    output cursor_row, output cell_data, input ready);
    modport sink   (input valid, input cursor_offset, input cursor_column,
                    input cursor_row, input cell_data, output ready);
endinterface

>>> rtl/core/tcw_ram.sv
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port with registered read data.
// ----------------------------------------------------------------------------
module tcw_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 2000
) (
    input  logic                     clk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end

endmodule

>>> rtl/core/tcw_sweep.sv
// ----------------------------------------------------------------------------
// Text console sweep unit
// Walks an address range one cell a cycle, filling it or copying each cell
// from one row further down.
// ----------------------------------------------------------------------------
module tcw_sweep (
    input  logic                        clk,
    input  logic                        rst_n,
    input  tcw_pkg::sweep_cmd_t         cmd,
    output logic                        busy,
    output logic                        ram_we,
    output logic [tcw_pkg::ADDR_W-1:0]  ram_waddr,
    output logic [tcw_pkg::CELL_W-1:0]  ram_wdata,
    output logic [tcw_pkg::ADDR_W-1:0]  ram_raddr,
    input  logic [tcw_pkg::CELL_W-1:0]  ram_rdata
);
    import tcw_pkg::*;

    logic              active_reg;
    logic              pend_reg;
    logic              copy_reg;
    logic [ADDR_W-1:0] cnt_reg;
    logic [ADDR_W-1:0] last_reg;
    logic [CELL_W-1:0] fill_reg;
    logic [ADDR_W-1:0] pend_addr_reg;

    assign busy      = active_reg | pend_reg;
    assign ram_raddr = cnt_reg + ADDR_W'(COLUMNS);

    // In copy mode the write comes in the cycle after the read, to meet the read data.
    always_comb
    begin
        if (copy_reg)
        begin
            ram_we    = pend_reg;
            ram_waddr = pend_addr_reg;
            ram_wdata = ram_rdata;
        end
        else
        begin
            ram_we    = active_reg;
            ram_waddr = cnt_reg;
            ram_wdata = fill_reg;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
            pend_reg   <= 1'b0;
        end
        else
        begin
            pend_reg <= active_reg & copy_reg;
            if (cmd.start)
            begin
                active_reg <= 1'b1;
            end
            else if (active_reg && (cnt_reg == last_reg))
            begin
                active_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        pend_addr_reg <= cnt_reg;
        if (cmd.start)
        begin
            copy_reg <= cmd.copy;
            cnt_reg  <= cmd.first;
            last_reg <= cmd.last;
            fill_reg <= cmd.fill;
        end
        else if (active_reg)
        begin
            cnt_reg <= cnt_reg + 1'b1;
        end
    end

endmodule

>>> rtl/core/text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer
// Character-cell console: screen store, cursor, wrap, scroll and clear.
// ----------------------------------------------------------------------------
// A scroll is a 1920-cell copy and an 80-cell blanking, one cell a cycle through
// the sweep unit and the single write port; a clear blanks all 2000 cells the
// same way. One command is in work at a time. After reset the store is filled
// with blanks before the first command transfer.
module text_console_writer (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cfg_we,
    input  logic [tcw_pkg::ATTR_W-1:0]  cfg_wdata,
    tcw_cmd_if.sink                     cmd,
    tcw_rsp_if.source                   rsp
);
    import tcw_pkg::*;

    typedef enum logic [2:0] {
        S_BOOT,
        S_BOOT_WAIT,
        S_IDLE,
        S_PUT,
        S_WAIT,
        S_READ,
        S_DONE
    } state_t;

    state_t            state_reg, state_next;
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [ATTR_W-1:0] attr_reg;
    logic [CHAR_W-1:0] ch_reg, ch_next;
    logic [TAB_W-1:0]  remain_reg, remain_next;
    logic              scroll_pend_reg, scroll_pend_next;
    logic              blank_pend_reg, blank_pend_next;
    logic              addr_ok_reg, addr_ok_next;
    logic [CELL_W-1:0] data_reg, data_next;
    logic              rsp_valid_reg, rsp_valid_next;
    logic [ADDR_W-1:0] rsp_off_reg, rsp_off_next;
    logic [COL_W-1:0]  rsp_col_reg, rsp_col_next;
    logic [ROW_W-1:0]  rsp_row_reg, rsp_row_next;
    logic [CELL_W-1:0] rsp_data_reg, rsp_data_next;

    sweep_cmd_t        sweep_cmd;
    logic              sweep_busy;
    logic              ram_we;
    logic [ADDR_W-1:0] ram_waddr;
    logic [CELL_W-1:0] ram_wdata;
    logic [ADDR_W-1:0] sweep_raddr;
    logic [ADDR_W-1:0] ram_raddr;
    logic [CELL_W-1:0] ram_rdata;

    logic [ADDR_W-1:0] cur_idx;
    logic [CELL_W-1:0] blank;
    logic              accept;

    assign cur_idx   = ADDR_W'(32'(row_reg) * COLUMNS + 32'(col_reg));
    assign blank     = {attr_reg, CH_SPACE};
    assign cmd.ready = (state_reg == S_IDLE);
    assign accept    = cmd.valid && (state_reg == S_IDLE);
    assign ram_raddr = sweep_busy ? sweep_raddr : cmd.cell_address;

    assign rsp.valid         = rsp_valid_reg;
    assign rsp.cursor_offset = rsp_off_reg;
    assign rsp.cursor_column = rsp_col_reg;
    assign rsp.cursor_row    = rsp_row_reg;
    assign rsp.cell_data     = rsp_data_reg;

    tcw_sweep u_sweep (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (sweep_cmd),
        .busy      (sweep_busy),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_raddr (sweep_raddr),
        .ram_rdata (ram_rdata)
    );

    tcw_ram #(
        .WIDTH (CELL_W),
        .DEPTH (CELLS)
    ) u_screen (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            attr_reg <= RESET_ATTR;
        end
        else if (cfg_we)
        begin
            attr_reg <= cfg_wdata;
        end
    end

    always_comb
    begin
        state_next       = state_reg;
        col_next         = col_reg;
        row_next         = row_reg;
        ch_next          = ch_reg;
        remain_next      = remain_reg;
        scroll_pend_next = scroll_pend_reg;
        blank_pend_next  = blank_pend_reg;
        addr_ok_next     = addr_ok_reg;
        data_next        = data_reg;
        rsp_valid_next   = rsp_valid_reg && !rsp.ready;
        rsp_off_next     = rsp_off_reg;
        rsp_col_next     = rsp_col_reg;
        rsp_row_next     = rsp_row_reg;
        rsp_data_next    = rsp_data_reg;
        sweep_cmd.start  = 1'b0;
        sweep_cmd.copy   = 1'b0;
        sweep_cmd.first  = cur_idx;
        sweep_cmd.last   = cur_idx;
        sweep_cmd.fill   = blank;

        case (state_reg)
            S_BOOT:
            begin
                sweep_cmd.start = 1'b1;
                sweep_cmd.first = '0;
                sweep_cmd.last  = ADDR_W'(CELLS - 1);
                sweep_cmd.fill  = RESET_BLANK;
                state_next      = S_BOOT_WAIT;
            end

            S_BOOT_WAIT:
            begin
                if (!sweep_busy)
                begin
                    state_next = S_IDLE;
                end
            end

            S_IDLE:
            begin
                if (accept)
                begin
                    data_next    = '0;
                    remain_next  = '0;
                    addr_ok_next = (32'(cmd.cell_address) < CELLS);
                    case (cmd.operation)
                        OP_PUT:
                        begin
                            if ((cmd.char_code == CH_BACKSPACE) && (col_reg != '0))
                            begin
                                sweep_cmd.start = 1'b1;
                                sweep_cmd.first = cur_idx - 1'b1;
                                sweep_cmd.last  = cur_idx - 1'b1;
                                col_next        = col_reg - 1'b1;
                                state_next      = S_WAIT;
                            end
                            else if (cmd.char_code == CH_TAB)
                            begin
                                ch_next     = CH_SPACE;
                                remain_next = TAB_W'(TAB_SPACES);
                                state_next  = S_PUT;
                            end
                            else if (cmd.char_code == CH_NEWLINE)
                            begin
                                col_next = '0;
                                if (row_reg == ROW_W'(ROWS - 1))
                                begin
                                    scroll_pend_next = 1'b1;
                                end
                                else
                                begin
                                    row_next = row_reg + 1'b1;
                                end
                                state_next = S_WAIT;
                            end
                            else
                            begin
                                ch_next     = cmd.char_code;
                                remain_next = TAB_W'(1);
                                state_next  = S_PUT;
                            end
                        end

                        OP_CLEAR:
                        begin
                            sweep_cmd.start = 1'b1;
                            sweep_cmd.first = '0;
                            sweep_cmd.last  = ADDR_W'(CELLS - 1);
                            col_next        = '0;
                            row_next        = '0;
                            state_next      = S_WAIT;
                        end

                        OP_READ:
                        begin
                            state_next = S_READ;
                        end

                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end

            S_PUT:
            begin
                sweep_cmd.start = 1'b1;
                sweep_cmd.fill  = {attr_reg, ch_reg};
                remain_next     = remain_reg - 1'b1;
                if (col_reg == COL_W'(COLUMNS - 1))
                begin
                    col_next = '0;
                    if (row_reg == ROW_W'(ROWS - 1))
                    begin
                        scroll_pend_next = 1'b1;
                    end
                    else
                    begin
                        row_next = row_reg + 1'b1;
                    end
                end
                else
                begin
                    col_next = col_reg + 1'b1;
                end
                state_next = S_WAIT;
            end

            S_WAIT:
            begin
                // A scroll is a row copy followed by blanking the bottom row.
                if (!sweep_busy)
                begin
                    if (scroll_pend_reg)
                    begin
                        sweep_cmd.start  = 1'b1;
                        sweep_cmd.copy   = 1'b1;
                        sweep_cmd.first  = '0;
                        sweep_cmd.last   = ADDR_W'(SCROLL_LAST);
                        scroll_pend_next = 1'b0;
                        blank_pend_next  = 1'b1;
                    end
                    else if (blank_pend_reg)
                    begin
                        sweep_cmd.start = 1'b1;
                        sweep_cmd.first = ADDR_W'(BOTTOM_FIRST);
                        sweep_cmd.last  = ADDR_W'(CELLS - 1);
                        blank_pend_next = 1'b0;
                    end
                    else if (remain_reg != '0)
                    begin
                        state_next = S_PUT;
                    end
                    else
                    begin
                        state_next = S_DONE;
                    end
                end
            end

            S_READ:
            begin
                data_next  = addr_ok_reg ? ram_rdata : '0;
                state_next = S_DONE;
            end

            S_DONE:
            begin
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next = 1'b1;
                    rsp_off_next   = cur_idx;
                    rsp_col_next   = col_reg;
                    rsp_row_next   = row_reg;
                    rsp_data_next  = data_reg;
                    state_next     = S_IDLE;
                end
            end

            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg       <= S_BOOT;
            col_reg         <= '0;
            row_reg         <= '0;
            ch_reg          <= '0;
            remain_reg      <= '0;
            scroll_pend_reg <= 1'b0;
            blank_pend_reg  <= 1'b0;
            addr_ok_reg     <= 1'b0;
            data_reg        <= '0;
            rsp_valid_reg   <= 1'b0;
            rsp_off_reg     <= '0;
            rsp_col_reg     <= '0;
            rsp_row_reg     <= '0;
            rsp_data_reg    <= '0;
        end
        else
        begin
            state_reg       <= state_next;
            col_reg         <= col_next;
            row_reg         <= row_next;
            ch_reg          <= ch_next;
            remain_reg      <= remain_next;
            scroll_pend_reg <= scroll_pend_next;
            blank_pend_reg  <= blank_pend_next;
            addr_ok_reg     <= addr_ok_next;
            data_reg        <= data_next;
            rsp_valid_reg   <= rsp_valid_next;
            rsp_off_reg     <= rsp_off_next;
            rsp_col_reg     <= rsp_col_next;
            rsp_row_reg     <= rsp_row_next;
            rsp_data_reg    <= rsp_data_next;
        end
    end

endmodule

>>> rtl/core/tcw_checker.sv
// ----------------------------------------------------------------------------
// Text console writer checker
// Port-level checks on the command and response channels of the console.
// ----------------------------------------------------------------------------
module tcw_checker (
    input  logic                        clk,
    input  logic                        rst_n,
    input  logic                        cmd_valid,
    input  logic                        cmd_ready,
    input  logic                        rsp_valid,
    input  logic                        rsp_ready,
    input  logic [tcw_pkg::ADDR_W-1:0]  rsp_offset,
    input  logic [tcw_pkg::COL_W-1:0]   rsp_column,
    input  logic [tcw_pkg::ROW_W-1:0]   rsp_row
);
    import tcw_pkg::*;

    // A finished result stays offered until its transfer.
    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && !rsp_ready |=> rsp_valid)
        else $error("response dropped before transfer");

    // One command is in work at a time.
    assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |=> !cmd_ready)
        else $error("command taken while another is in work");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_column) < COLUMNS) && (32'(rsp_row) < ROWS))
        else $error("cursor outside the screen");

    assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid |-> (32'(rsp_offset) == 32'(rsp_row) * COLUMNS + 32'(rsp_column)))
        else $error("cursor offset does not match row and column");

endmodule

bind text_console_writer tcw_checker u_tcw_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .cmd_valid  (cmd.valid),
    .cmd_ready  (cmd.ready),
    .rsp_valid  (rsp.valid),
    .rsp_ready  (rsp.ready),
    .rsp_offset (rsp.cursor_offset),
    .rsp_column (rsp.cursor_column),
    .rsp_row    (rsp.cursor_row)
);

>>> test/tb_text_console_writer.sv
// ----------------------------------------------------------------------------
// Text console writer testbench
// Drives put, clear and read commands, plus the unused operation code, through
// the command channel and checks every response against a cycle-free model of
// the screen store and cursor kept here or the result a directed row gives. A
// short directed table, then random text, newlines, tabs, backspaces, reads,
// clears and unused codes in three idling patterns, new attribute per phase.
// ----------------------------------------------------------------------------
module tb_text_console_writer;
    timeunit 1ns;
    timeprecision 1ps;

    import tcw_pkg::*;

    localparam logic [OP_W-1:0] OP_UNUSED = 2'd3;
    localparam int              ADDR_TOP  = (1 << ADDR_W) - 1;
    localparam int              CYCLE_LIMIT = 5_000_000;
    localparam int              MAX_REPORTED = 10;

    typedef struct packed {
        logic [ADDR_W-1:0] offset;
        logic [COL_W-1:0]  column;
        logic [ROW_W-1:0]  row;
        logic [CELL_W-1:0] data;
    } cursor_report_t;

    typedef struct packed {
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        cursor_report_t    want;
    } console_row_t;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [ATTR_W-1:0] cfg_wdata;

    tcw_cmd_if cmd_ch ();
    tcw_rsp_if rsp_ch ();

    text_console_writer DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_wdata (cfg_wdata),
        .cmd       (cmd_ch),
        .rsp       (rsp_ch)
    );

    // Shadow copy of the console state.
    logic [CELL_W-1:0] screen_mirror [CELLS];
    int unsigned       mirror_col;
    int unsigned       mirror_row;
    logic [ATTR_W-1:0] mirror_attr;

    cursor_report_t pending_reports [$];
    int unsigned    error_count;
    int unsigned    mismatch_count;
    longint unsigned cycle_count;
    int unsigned    send_idle_pct;
    int unsigned    recv_idle_pct;
    bit             cmd_held;

    // The first rows can be read off a freshly reset console directly.
    console_row_t directed_rows [0:19] = '{
        '{OP_READ,   8'h00,        11'd0,    1'b1, '{11'd0, 7'd0, 5'd0, RESET_BLANK}},
        '{OP_READ,   8'h00,        11'd1999, 1'b1, '{11'd0, 7'd0, 5'd0, RESET_BLANK}},
        '{OP_READ,   8'h00,        11'd2000, 1'b1, '{11'd0, 7'd0, 5'd0, 16'h0000}},
        '{OP_READ,   8'hFF,        11'd2047, 1'b1, '{11'd0, 7'd0, 5'd0, 16'h0000}},
        '{OP_UNUSED, 8'hFF,        11'd2047, 1'b1, '{11'd0, 7'd0, 5'd0, 16'h0000}},
        '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b0, '0},
        '{OP_PUT,    8'h41,        11'd0,    1'b0, '0},
        '{OP_PUT,    8'h00,        11'd0,    1'b0, '0},
        '{OP_PUT,    8'hFF,        11'd0,    1'b0, '0},
        '{OP_PUT,    CH_BACKSPACE, 11'd0,    1'b0, '0},
        '{OP_READ,   8'h00,        11'd3,    1'b0, '0},
        '{OP_READ,   8'h00,        11'd0,    1'b0, '0},
        '{OP_PUT,    CH_TAB,       11'd0,    1'b0, '0},
        '{OP_PUT,    CH_NEWLINE,   11'd0,    1'b0, '0},
        '{OP_PUT,    8'h7F,        11'd0,    1'b0, '0},
        '{OP_READ,   8'h00,        11'd80,   1'b0, '0},
        '{OP_CLEAR,  8'h00,        11'd0,    1'b1, '{11'd0, 7'd0, 5'd0, 16'h0000}},
        '{OP_READ,   8'h00,        11'd0,    1'b1, '{11'd0, 7'd0, 5'd0, RESET_BLANK}},
        '{OP_PUT,    8'h80,        11'd0,    1'b0, '0},
        '{OP_PUT,    CH_NEWLINE,   11'd1024, 1'b0, '0}
    };

    always #6 clk = ~clk;

    function automatic logic [CELL_W-1:0] mirror_blank();
        return {mirror_attr, CH_SPACE};
    endfunction

    function automatic void mirror_reset();
        for (int i = 0; i < CELLS; i++)
        begin
            screen_mirror[i] = RESET_BLANK;
        end
        mirror_col  = 0;
        mirror_row  = 0;
        mirror_attr = RESET_ATTR;
    endfunction

    // Wrap at the row end, then scroll once the cursor has left the last row.
    function automatic void mirror_settle();
        if (mirror_col >= COLUMNS)
        begin
            mirror_col = 0;
            mirror_row++;
        end
        if (mirror_row >= ROWS)
        begin
            for (int i = 0; i < (ROWS - 1) * COLUMNS; i++)
            begin
                screen_mirror[i] = screen_mirror[i + COLUMNS];
            end
            for (int i = (ROWS - 1) * COLUMNS; i < CELLS; i++)
            begin
                screen_mirror[i] = mirror_blank();
            end
            mirror_row = ROWS - 1;
        end
    endfunction

    function automatic void mirror_plain(logic [CHAR_W-1:0] ch);
        int unsigned idx;
        idx = mirror_row * COLUMNS + mirror_col;
        if (idx < CELLS)
        begin
            screen_mirror[idx] = {mirror_attr, ch};
        end
        mirror_col++;
        mirror_settle();
    endfunction

    function automatic void mirror_put(logic [CHAR_W-1:0] ch);
        int unsigned idx;
        if (ch == CH_BACKSPACE && mirror_col != 0)
        begin
            idx = mirror_row * COLUMNS + mirror_col - 1;
            if (idx < CELLS)
            begin
                screen_mirror[idx] = mirror_blank();
            end
            mirror_col--;
            mirror_settle();
        end
        else if (ch == CH_TAB)
        begin
            for (int k = 0; k < TAB_SPACES; k++)
            begin
                mirror_plain(CH_SPACE);
            end
            mirror_settle();
        end
        else if (ch == CH_NEWLINE)
        begin
            mirror_col = 0;
            mirror_row++;
            mirror_settle();
        end
        else
        begin
            mirror_plain(ch);
        end
    endfunction

    function automatic cursor_report_t console_step(logic [OP_W-1:0] op,
                                                    logic [CHAR_W-1:0] ch,
                                                    logic [ADDR_W-1:0] addr);
        cursor_report_t report;
        int unsigned    offset;
        report.data = '0;
        if (op == OP_PUT)
        begin
            mirror_put(ch);
        end
        else if (op == OP_CLEAR)
        begin
            for (int i = 0; i < CELLS; i++)
            begin
                screen_mirror[i] = mirror_blank();
            end
            mirror_col = 0;
            mirror_row = 0;
        end
        else if (op == OP_READ && addr < CELLS)
        begin
            report.data = screen_mirror[addr];
        end
        offset        = mirror_row * COLUMNS + mirror_col;
        report.offset = offset[ADDR_W-1:0];
        report.column = mirror_col[COL_W-1:0];
        report.row    = mirror_row[ROW_W-1:0];
        return report;
    endfunction

    // One command transfer; valid stays high afterwards unless a gap follows.
    task automatic send_command(logic [OP_W-1:0] op, logic [CHAR_W-1:0] ch,
                                logic [ADDR_W-1:0] addr, logic typed,
                                cursor_report_t want);
        cursor_report_t report;
        if ($urandom_range(0, 99) < send_idle_pct)
        begin
            cmd_ch.valid <= 1'b0;
            @(posedge clk);
            while ($urandom_range(0, 99) < send_idle_pct)
            begin
                @(posedge clk);
            end
        end
        cmd_ch.valid        <= 1'b1;
        cmd_ch.operation    <= op;
        cmd_ch.char_code    <= ch;
        cmd_ch.cell_address <= addr;
        cmd_held = 1'b1;
        @(posedge clk);
        while (!cmd_ch.ready)
        begin
            @(posedge clk);
        end
        report = console_step(op, ch, addr);
        pending_reports.push_back(typed ? want : report);
    endtask

    // Holds the sender off until every response has come back.
    task automatic drain_responses();
        if (cmd_held)
        begin
            cmd_ch.valid <= 1'b0;
            cmd_held = 1'b0;
        end
        while (pending_reports.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic write_attribute(logic [ATTR_W-1:0] value);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we    <= 1'b0;
        mirror_attr = value;
    endtask

    task automatic send_random_command();
        int unsigned       pick;
        int unsigned       near_cell;
        logic [OP_W-1:0]   op;
        logic [CHAR_W-1:0] ch;
        logic [ADDR_W-1:0] addr;
        pick = $urandom_range(0, 999);
        op   = OP_PUT;
        ch   = CHAR_W'($urandom_range(0, 255));
        addr = ($urandom_range(0, 99) < 85) ? ADDR_W'($urandom_range(0, CELLS - 1))
                                            : ADDR_W'($urandom_range(CELLS, ADDR_TOP));
        if (pick < 5)
        begin
            op = OP_CLEAR;
        end
        else if (pick < 25)
        begin
            op = OP_UNUSED;
        end
        else if (pick < 155)
        begin
            op = OP_READ;
            // Half the reads look at the cell just before the cursor.
            if ($urandom_range(0, 1) == 1)
            begin
                near_cell = mirror_row * COLUMNS + mirror_col;
                addr = (near_cell > 0) ? ADDR_W'(near_cell - 1) : '0;
            end
        end
        else if (pick < 235)
        begin
            ch = CH_BACKSPACE;
        end
        else if (pick < 295)
        begin
            ch = CH_TAB;
        end
        else if (pick < 495)
        begin
            ch = CH_NEWLINE;
        end
        send_command(op, ch, addr, 1'b0, '0);
    endtask

    task automatic run_random_phase(int unsigned send_pct, int unsigned recv_pct,
                                    int unsigned count);
        send_idle_pct = send_pct;
        recv_idle_pct = recv_pct;
        for (int n = 0; n < count; n++)
        begin
            send_random_command();
            if ($urandom_range(0, 59) == 0)
            begin
                drain_responses();
            end
        end
        drain_responses();
    endtask

    always @(posedge clk)
    begin
        rsp_ch.ready <= ($urandom_range(0, 99) >= recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count > CYCLE_LIMIT)
        begin
            $display("tb_text_console_writer NOT OK");
            $finish;
        end
    end

    always @(posedge clk)
    begin
        cursor_report_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_reports.size() == 0)
            begin
                error_count++;
                mismatch_count++;
                if (mismatch_count <= MAX_REPORTED)
                begin
                    $display("%0t: response with no command outstanding", $realtime);
                end
            end
            else
            begin
                want = pending_reports.pop_front();
                if (rsp_ch.cursor_offset !== want.offset
                    || rsp_ch.cursor_column !== want.column
                    || rsp_ch.cursor_row !== want.row
                    || rsp_ch.cell_data !== want.data)
                begin
                    error_count++;
                    mismatch_count++;
                    if (mismatch_count <= MAX_REPORTED)
                    begin
                        $display({"%0t: mismatch offset %0d/%0d column %0d/%0d",
                                  " row %0d/%0d data %h/%h (expected/actual)"},
                                 $realtime, want.offset, rsp_ch.cursor_offset,
                                 want.column, rsp_ch.cursor_column, want.row,
                                 rsp_ch.cursor_row, want.data, rsp_ch.cell_data);
                    end
                end
            end
        end
    end

    initial
    begin
        clk                 = 1'b0;
        rst_n               = 1'b0;
        cfg_we              = 1'b0;
        cfg_wdata           = '0;
        cmd_ch.valid        = 1'b0;
        cmd_ch.operation    = OP_PUT;
        cmd_ch.char_code    = '0;
        cmd_ch.cell_address = '0;
        rsp_ch.ready        = 1'b0;
        error_count         = 0;
        mismatch_count      = 0;
        cycle_count         = 0;
        cmd_held            = 1'b0;
        send_idle_pct       = 18;
        recv_idle_pct       = 81;
        mirror_reset();

        repeat (9) @(posedge clk);
        rst_n <= 1'b1;

        // Directed commands run with the reset attribute.
        foreach (directed_rows[i])
        begin
            send_command(directed_rows[i].op, directed_rows[i].ch, directed_rows[i].addr,
                         directed_rows[i].typed, directed_rows[i].want);
        end
        drain_responses();

        write_attribute(8'h00);
        run_random_phase(18, 81, 170);
        write_attribute(8'hFF);
        run_random_phase(81, 18, 170);
        write_attribute(ATTR_W'($urandom_range(1, 254)));
        run_random_phase(0, 0, 160);

        // Allow a late extra response to show up before the verdict.
        repeat (20) @(posedge clk);
        if (error_count == 0)
        begin
            $display("tb_text_console_writer OK");
        end
        else
        begin
            $display("tb_text_console_writer NOT OK");
        end
        $finish;
    end

endmodule

>>> files.f
rtl/core/tcw_pkg.sv
rtl/core/tcw_if.sv
rtl/core/tcw_ram.sv
rtl/core/tcw_sweep.sv
rtl/core/text_console_writer.sv
rtl/core/tcw_checker.sv
test/tb_text_console_writer.sv
